FILE: hdl/gdpo_pkg.sv
// ----------------------------------------------------------------------------
// gdpo_pkg
// Shared types and constants for the gesture direction peak order unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gdpo_pkg;

  localparam int PHASE_BITS   = 16;
  localparam int SAMPLE_BITS  = 8;
  localparam int NUM_CHANNELS = 4;
  localparam int DIR_BITS     = 3;

  localparam int IN_DATA_BITS  = NUM_CHANNELS * SAMPLE_BITS;
  localparam int OUT_DATA_BITS = 8;

  localparam logic [SAMPLE_BITS-1:0] NOISE_LEVEL_RESET = SAMPLE_BITS'(2);

  typedef logic [PHASE_BITS-1:0]  phase_t;
  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [DIR_BITS-1:0] {
    DIR_NONE  = 3'd0,
    DIR_UP    = 3'd1,
    DIR_DOWN  = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_RIGHT = 3'd4
  } dir_t;

  typedef enum int {
    CH_UP    = 0,
    CH_DOWN  = 1,
    CH_LEFT  = 2,
    CH_RIGHT = 3
  } chan_t;

  // Result beat as it sits in the output register.
  typedef struct packed {
    logic evaluated;
    logic tracking;
    dir_t direction;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/gesture_direction_peak_order_unit.sv
// ----------------------------------------------------------------------------
// gesture_direction_peak_order_unit
// Decides a swipe direction from the order in which four channels peak.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one four-channel sample per beat (up in the lowest byte).
//   m_axis returns exactly one result beat per sample, in order: the held
//   direction, a tracking flag and an evaluated flag.
//   cfg_valid/cfg_ready/cfg_data write the noise level; cfg_ready is always
//   high. Write it only while no sample is in flight.
// Pipeline and throughput:
//   A sample accepted into the input register is processed by the compare and
//   update logic and lands in the output register once that register is empty
//   or its beat is taken. The single stage between the input and output
//   registers takes one sample per cycle while m_axis_tready stays high, so the
//   unit then sustains one beat per cycle.
// Reset:
//   rst clears both pipeline valid flags, all channel maxima, peak phases, the
//   phase counter and the held direction; the noise level returns to 2.
// Stalls:
//   When m_axis_tready is low the output register holds its beat; the input
//   register takes one more sample if it is empty, then s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module gesture_direction_peak_order_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // tdata: up_sample[7:0], down_sample[15:8], left_sample[23:16],
  //        right_sample[31:24]
  input  wire logic [gdpo_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tdata: direction[2:0], tracking[3], evaluated[4], zero[7:5]
  output logic [gdpo_pkg::OUT_DATA_BITS-1:0]       m_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  input  wire logic [gdpo_pkg::SAMPLE_BITS-1:0]    cfg_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready
);

  import gdpo_pkg::*;

  localparam phase_t PHASE_MAX = '1;

  sample_t gate_level;

  logic    in_valid;
  sample_t in_sample [NUM_CHANNELS];

  sample_t channel_max [NUM_CHANNELS];
  phase_t  peak_stamp  [NUM_CHANNELS];
  phase_t  phase_count;
  dir_t    held_direction;

  logic    out_valid;
  result_t out_result;

  logic    advance;
  logic    pass;
  logic    rose;
  logic [NUM_CHANNELS-1:0] ch_rise;
  dir_t    decision;
  result_t result_next;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_BITS - $bits(result_t)){1'b0}}, out_result};

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_level <= NOISE_LEVEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gate_level <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        in_sample[i] <= s_axis_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
      end
    end
  end

  always_comb begin
    pass = 1'b1;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      ch_rise[i] = in_sample[i] > channel_max[i];
      if (in_sample[i] <= gate_level) begin
        pass = 1'b0;
      end
    end
    rose = |ch_rise;
  end

  // Latest peak wins; later checks override earlier ones, which gives the
  // right, left, down, up priority when several hold.
  always_comb begin
    phase_t u, d, l, r;
    u = peak_stamp[CH_UP];
    d = peak_stamp[CH_DOWN];
    l = peak_stamp[CH_LEFT];
    r = peak_stamp[CH_RIGHT];
    decision = DIR_NONE;
    if (u > d && u >= l && u >= r) begin
      decision = DIR_UP;
    end
    if (d > u && d >= l && d >= r) begin
      decision = DIR_DOWN;
    end
    if (l >= u && l >= d && l > r) begin
      decision = DIR_LEFT;
    end
    if (r >= u && r >= d && r > l) begin
      decision = DIR_RIGHT;
    end
  end

  always_comb begin
    result_next.tracking  = pass;
    result_next.evaluated = pass && !rose;
    if (!pass) begin
      result_next.direction = DIR_NONE;
    end else if (!rose) begin
      result_next.direction = decision;
    end else begin
      result_next.direction = held_direction;
    end
  end

  // Tracking state; updated only when a sample moves to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        channel_max[i] <= '0;
        peak_stamp[i]  <= '0;
      end
      phase_count    <= '0;
      held_direction <= DIR_NONE;
    end else if (advance) begin
      if (!pass) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          channel_max[i] <= '0;
          peak_stamp[i]  <= '0;
        end
        phase_count    <= '0;
        held_direction <= DIR_NONE;
      end else begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (ch_rise[i]) begin
            channel_max[i] <= in_sample[i];
            peak_stamp[i]  <= phase_count;
          end
        end
        if (phase_count != PHASE_MAX) begin
          phase_count <= phase_count + PHASE_BITS'(1);
        end
        held_direction <= result_next.direction;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/gdpo_checker.sv
// ----------------------------------------------------------------------------
// gdpo_checker
// Port-level checks for the gesture direction peak order unit.
// ----------------------------------------------------------------------------
`default_nettype none

module gdpo_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic [gdpo_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  input wire logic                                cfg_valid,
  input wire logic                                cfg_ready
);

  import gdpo_pkg::*;

  result_t res;
  assign res = result_t'(m_axis_tdata[$bits(result_t)-1:0]);

  // A stalled result beat must not change or vanish.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // A sample that failed the noise gate clears the decision.
  a_gate_clears: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !res.tracking |-> res.direction == DIR_NONE && !res.evaluated)
    else $error("untracked result carries a direction or evaluation");

  // An evaluation only happens on a tracked sample.
  a_eval_tracked: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.evaluated |-> res.tracking)
    else $error("evaluated without tracking");

  // No result is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result offered right after reset");

  // The configuration port never backpressures.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind gesture_direction_peak_order_unit gdpo_checker u_gdpo_checker (.*);

`default_nettype wire

FILE: dv/gesture_direction_peak_order_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gesture_direction_peak_order_unit_tb
// Self-checking stream testbench for the gesture direction peak order unit.
// A queue of sample beats and noise level writes feeds a clocked driver.
// A clocked monitor tracks the channel peaks in its own model of the unit
// and checks every result beat, field by field, in order. Both sides stall
// at random. The stimulus covers directed swipes, random swipes under
// several noise levels, noise and broken swipes, and a steady tracked run
// that ends on a clear swipe.
// ----------------------------------------------------------------------------

module gesture_direction_peak_order_unit_tb;
  import gdpo_pkg::*;

  localparam int QUIET_NEEDED = 4;    // cycles of silence before a noise write or sync beat
  localparam int HOLD_AT      = 300;  // result beat after which the sink holds off
  localparam int HOLD_CYCLES  = 300;
  localparam int LEVEL_BEATS  = 180;
  localparam int LONG_RUN     = 48;

  typedef struct packed {
    logic        is_cfg;
    logic        sync;
    logic [7:0]  cfg;
    logic [31:0] beat;
    logic [3:0]  gap;
  } job_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [SAMPLE_BITS-1:0]   cfg_data = '0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;

  gesture_direction_peak_order_unit dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_data     (cfg_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Model of the unit's tracking state.
  sample_t noise_ref;
  sample_t chan_peak [NUM_CHANNELS];
  phase_t  peak_at [NUM_CHANNELS];
  phase_t  phase_ctr;
  dir_t    held_ref;

  job_t    sample_jobs [$];
  result_t pending_results [$];

  logic    sample_taken = 1'b0;
  logic    cfg_taken = 1'b0;
  logic    result_taken = 1'b0;
  int      quiet_cycles = 0;
  int      errors = 0;
  int      samples_in = 0;
  int      results_out = 0;
  int      cfg_writes = 0;
  int      dir_seen [5];

  function automatic void clear_peaks();
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      chan_peak[c] = '0;
      peak_at[c] = '0;
    end
    phase_ctr = '0;
    held_ref = DIR_NONE;
  endfunction

  // The channel whose peak came last wins; right, left, down, up in priority.
  function automatic dir_t latest_peak();
    phase_t u, d, l, r;
    dir_t   w;
    u = peak_at[CH_UP];
    d = peak_at[CH_DOWN];
    l = peak_at[CH_LEFT];
    r = peak_at[CH_RIGHT];
    w = DIR_NONE;
    if (u > d && u >= l && u >= r) w = DIR_UP;
    if (d > u && d >= l && d >= r) w = DIR_DOWN;
    if (l >= u && l >= d && l > r) w = DIR_LEFT;
    if (r >= u && r >= d && r > l) w = DIR_RIGHT;
    return w;
  endfunction

  function automatic result_t track_sample(logic [IN_DATA_BITS-1:0] beat);
    sample_t s [NUM_CHANNELS];
    logic    pass;
    logic    rose;
    result_t r;
    pass = 1'b1;
    rose = 1'b0;
    r = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      s[c] = beat[c*SAMPLE_BITS +: SAMPLE_BITS];
      if (s[c] <= noise_ref) pass = 1'b0;
    end
    if (!pass) begin
      clear_peaks();
      r.direction = DIR_NONE;
      return r;
    end
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (s[c] > chan_peak[c]) begin
        chan_peak[c] = s[c];
        peak_at[c] = phase_ctr;
        rose = 1'b1;
      end
    end
    if (!rose) begin
      held_ref = latest_peak();
      r.evaluated = 1'b1;
    end
    if (phase_ctr != '1) phase_ctr = phase_ctr + 1'b1;
    r.direction = held_ref;
    r.tracking = 1'b1;
    return r;
  endfunction

  function automatic logic [31:0] pack4(int unsigned u, int unsigned d, int unsigned l,
                                        int unsigned r);
    return {r[7:0], l[7:0], d[7:0], u[7:0]};
  endfunction

  task automatic queue_sample(logic [31:0] beat, int unsigned gap, logic sync);
    job_t j;
    j = '0;
    j.beat = beat;
    j.gap = gap[3:0];
    j.sync = sync;
    sample_jobs.push_back(j);
  endtask

  task automatic queue_noise_level(int unsigned level);
    job_t j;
    j = '0;
    j.is_cfg = 1'b1;
    j.cfg = level[7:0];
    j.gap = 4'($urandom_range(0, 9));
    sample_jobs.push_back(j);
  endtask

  // One swipe: each channel ramps up to its own peak beat and falls off again,
  // with some noise beats mixed in, and ends on a beat that fails the gate.
  task automatic queue_swipe(int unsigned level, output int unsigned count);
    int unsigned len, lo, away, v, fall, c_fail;
    int unsigned pk [NUM_CHANNELS];
    int unsigned top [NUM_CHANNELS];
    int unsigned drop [NUM_CHANNELS];
    logic [31:0] beat;
    logic        burst;
    logic        sync;
    lo = level + 1;
    len = $urandom_range(3, 12);
    burst = ($urandom_range(0, 5) == 0);
    sync = ($urandom_range(0, 39) == 0);
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      pk[c] = $urandom_range(0, len - 1);
      top[c] = (lo > 255) ? 255 : $urandom_range(lo, 255);
      drop[c] = $urandom_range(1, 12);
    end
    for (int unsigned t = 0; t < len + 2; t++) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        away = (t > pk[c]) ? t - pk[c] : pk[c] - t;
        fall = away * drop[c];
        v = (top[c] >= fall + lo) ? top[c] - fall : lo;
        if (v > 255) v = 255;
        beat[c*SAMPLE_BITS +: SAMPLE_BITS] = v[7:0];
      end
      if ($urandom_range(0, 15) == 0) beat = $urandom;
      queue_sample(beat, burst ? 0 : $urandom_range(0, 9), sync && t == 0);
    end
    beat = $urandom;
    c_fail = $urandom_range(0, NUM_CHANNELS - 1);
    beat[c_fail*SAMPLE_BITS +: SAMPLE_BITS] = 8'($urandom_range(0, level));
    queue_sample(beat, burst ? 0 : $urandom_range(0, 9), 1'b0);
    count = len + 3;
  endtask

  // Driver: sample and noise level beats change on the falling edge.
  job_t        cur_job;
  logic        have_job = 1'b0;
  logic [3:0]  gap_left = '0;
  logic        nv, ncv;
  logic [31:0] nd;
  logic [7:0]  ncd;

  always @(negedge clk) begin
    nv = s_axis_tvalid;
    nd = s_axis_tdata;
    ncv = cfg_valid;
    ncd = cfg_data;
    if (!rst) begin
      if (s_axis_tvalid && sample_taken) nv = 1'b0;
      if (cfg_valid && cfg_taken) ncv = 1'b0;
      if (!nv && !ncv) begin
        if (!have_job && sample_jobs.size() > 0) begin
          cur_job = sample_jobs.pop_front();
          have_job = 1'b1;
          gap_left = cur_job.gap;
        end
        if (have_job) begin
          if (gap_left > 0) begin
            gap_left--;
          end else if ((cur_job.is_cfg || cur_job.sync) &&
                       !(pending_results.size() == 0 && quiet_cycles >= QUIET_NEEDED)) begin
            // Hold until the unit has drained.
          end else begin
            if (cur_job.is_cfg) begin
              ncv = 1'b1;
              ncd = cur_job.cfg;
            end else begin
              nv = 1'b1;
              nd = cur_job.beat;
            end
            have_job = 1'b0;
          end
        end
      end
    end
    s_axis_tvalid <= nv;
    s_axis_tdata <= nd;
    cfg_valid <= ncv;
    cfg_data <= ncd;
  end

  // Sink: draws a stall per result beat, with calm stretches and one long hold.
  int rx_count = 0;
  int rx_wait = 0;

  always @(negedge clk) begin
    if (!rst) begin
      if (result_taken) begin
        rx_count++;
        if (rx_count == HOLD_AT) rx_wait = HOLD_CYCLES;
        else if ((rx_count % 512) >= 384) rx_wait = 0;
        else rx_wait = $urandom_range(0, 9);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
    end
    m_axis_tready <= !rst && (rx_wait == 0);
  end

  // Monitor: prediction on accepted input beats, checking on result beats.
  result_t want;

  always @(posedge clk) begin
    sample_taken <= !rst && s_axis_tvalid && s_axis_tready;
    cfg_taken <= !rst && cfg_valid && cfg_ready;
    result_taken <= !rst && m_axis_tvalid && m_axis_tready;
    if (rst) begin
      noise_ref = NOISE_LEVEL_RESET;
      clear_peaks();
    end else begin
      if (cfg_valid && cfg_ready) begin
        noise_ref = cfg_data;
        cfg_writes++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_out++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t unexpected result beat: expected none, got %h", $time, m_axis_tdata);
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata[2:0] !== want.direction) begin
            errors++;
            $display("%0t direction mismatch: expected %0d, got %0d",
                     $time, want.direction, m_axis_tdata[2:0]);
          end
          if (m_axis_tdata[3] !== want.tracking) begin
            errors++;
            $display("%0t tracking mismatch: expected %0b, got %0b",
                     $time, want.tracking, m_axis_tdata[3]);
          end
          if (m_axis_tdata[4] !== want.evaluated) begin
            errors++;
            $display("%0t evaluated mismatch: expected %0b, got %0b",
                     $time, want.evaluated, m_axis_tdata[4]);
          end
          if (m_axis_tdata[7:5] !== 3'b000) begin
            errors++;
            $display("%0t padding mismatch: expected 0, got %0d", $time, m_axis_tdata[7:5]);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = track_sample(s_axis_tdata);
        pending_results.push_back(want);
        samples_in++;
        if (want.evaluated && want.direction <= DIR_RIGHT) dir_seen[want.direction]++;
      end
    end
    quiet_cycles <= (pending_results.size() == 0 && !s_axis_tvalid && !cfg_valid) ?
                    ((quiet_cycles < 100) ? quiet_cycles + 1 : quiet_cycles) : 0;
  end

  initial begin
    int unsigned levels [8];
    int unsigned n, made, lvl;
    for (int i = 0; i < 5; i++) dir_seen[i] = 0;

    // Directed part at the reset noise level of 2.
    queue_sample(pack4(0, 0, 0, 0), 0, 1'b0);
    queue_sample(pack4(255, 255, 255, 255), 0, 1'b0);
    queue_sample(pack4(255, 255, 255, 255), 0, 1'b0);  // all peaks tied
    queue_sample(pack4(2, 3, 3, 3), 0, 1'b0);          // one channel at the level
    queue_sample(pack4(3, 3, 3, 3), 0, 1'b0);          // just above the level
    for (int w = 0; w < NUM_CHANNELS; w++) begin
      int unsigned v [NUM_CHANNELS];
      for (int c = 0; c < NUM_CHANNELS; c++) v[c] = (c == w) ? 1 : 200;
      queue_sample(pack4(v[0], v[1], v[2], v[3]), 1, 1'b0);
      queue_sample(pack4(10, 10, 10, 10), 0, 1'b0);
      for (int c = 0; c < NUM_CHANNELS; c++) v[c] = (c == w) ? 50 : 10;
      queue_sample(pack4(v[0], v[1], v[2], v[3]), 0, 1'b0);
      queue_sample(pack4(v[0], v[1], v[2], v[3]), 2, 1'b0);
    end
    // A channel rises after a decision: the direction is held.
    queue_sample(pack4(50, 10, 10, 70), 0, 1'b0);
    // Up and left peak together: left takes priority.
    queue_sample(pack4(0, 9, 9, 9), 0, 1'b0);
    queue_sample(pack4(10, 10, 10, 10), 0, 1'b0);
    queue_sample(pack4(50, 10, 50, 10), 0, 1'b0);
    queue_sample(pack4(50, 10, 50, 10), 0, 1'b0);

    // Random swipes under several noise levels, extremes among them.
    levels[0] = 0;
    levels[1] = 37;
    levels[2] = 255;
    levels[3] = $urandom_range(1, 120);
    levels[4] = 200;
    levels[5] = $urandom_range(0, 255);
    levels[6] = 1;
    levels[7] = 128;
    for (int p = 0; p < 8; p++) begin
      queue_noise_level(levels[p]);
      n = 0;
      while (n < LEVEL_BEATS) begin
        queue_swipe(levels[p], made);
        n += made;
      end
    end

    // Steady tracked run with back to back beats, then a late right peak.
    lvl = 5;
    queue_noise_level(lvl);
    queue_sample(pack4(0, 0, 0, 0), 0, 1'b0);
    for (int i = 0; i < LONG_RUN; i++)
      queue_sample(pack4($urandom_range(6, 200), $urandom_range(6, 200),
                         $urandom_range(6, 200), $urandom_range(6, 200)), 0, 1'b0);
    queue_sample(pack4(100, 100, 100, 255), 0, 1'b0);
    queue_sample(pack4(100, 100, 100, 255), 0, 1'b0);
    queue_sample(pack4(100, 100, 100, 100), 0, 1'b0);
    queue_noise_level(2);
    queue_sample(pack4(3, 3, 3, 3), 0, 1'b0);

    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (sample_jobs.size() != 0 || have_job || s_axis_tvalid || cfg_valid) @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t missing results: expected %0d more beats, got none",
               $time, pending_results.size());
    end

    $display("Covered %0d sample beats and %0d result beats over %0d noise level writes.",
             samples_in, results_out, cfg_writes);
    $display("Decisions: none %0d, up %0d, down %0d, left %0d, right %0d.",
             dir_seen[DIR_NONE], dir_seen[DIR_UP], dir_seen[DIR_DOWN],
             dir_seen[DIR_LEFT], dir_seen[DIR_RIGHT]);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(60_000_000);
    $display("Timeout with %0d results outstanding.", pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
